FILE: src/ldt_pkg.sv
// Shared types, codes and helpers for the recency-ordered track table.
// No dependencies; used by ldt_cell and lru_dedup_table_with_expiry.
package ldt_pkg;

   localparam int KEY_W   = 32;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 4;

   localparam logic [3:0] NO_DIRECTION = 4'hF;

   // command codes
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_PRUNE  = 1'b1;

   // track kinds
   localparam logic [1:0] KIND_IN  = 2'd0;
   localparam logic [1:0] KIND_OUT = 2'd1;

   // outcome codes
   localparam logic [1:0] OUT_REFRESH = 2'd0;
   localparam logic [1:0] OUT_INSERT  = 2'd1;
   localparam logic [1:0] OUT_EVICT   = 2'd2;
   localparam logic [1:0] OUT_PRUNE   = 2'd3;

   // cell operation codes
   typedef logic [2:0] op_type;
   localparam op_type OP_HOLD    = 3'd0;
   localparam op_type OP_MARK    = 3'd1;
   localparam op_type OP_COMPACT = 3'd2;
   localparam op_type OP_SEARCH  = 3'd3;
   localparam op_type OP_MOVE    = 3'd4;
   localparam op_type OP_REFRESH = 3'd5;
   localparam op_type OP_INSERT  = 3'd6;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic        command;
      logic [15:0] name_id;
      logic [7:0]  race_id;
      logic [3:0]  direction;
      logic [1:0]  track_kind;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0] outcome;
      count_type  live_count;
      count_type  pruned_count;
   } rsp_type;

   typedef struct packed {
      logic      valid;
      key_type   key;
      stamp_type stamp;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      op_type    op;
      key_type   key;
      stamp_type now;
      stamp_type threshold;
   } cell_ctrl_type;

   // what a cell shows its neighbors and the controller
   typedef struct packed {
      entry_type entry;
      logic      hit;
      logic      drop;
   } cell_status_type;

   function automatic key_type make_key(input req_type req);
      logic [3:0] from_dir;
      logic [3:0] to_dir;
      from_dir = (req.track_kind == KIND_IN)  ? req.direction : NO_DIRECTION;
      to_dir   = (req.track_kind == KIND_OUT) ? req.direction : NO_DIRECTION;
      return {req.name_id, req.race_id, from_dir, to_dir};
   endfunction

endpackage

FILE: src/ldt_cell.sv
// One slot of the recency chain: holds an entry, a hit flag and a drop flag.
// Depends on ldt_pkg; exchanges entries with its left and right neighbors.
module ldt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  ldt_pkg::cell_ctrl_type   ctrl,
   input  logic                     pair_right,
   input  ldt_pkg::cell_status_type left_in,
   input  ldt_pkg::cell_status_type right_in,
   output ldt_pkg::cell_status_type status
);

   ldt_pkg::entry_type entry_ff, entry_in;
   logic               hit_ff, hit_in;
   logic               drop_ff, drop_in;
   ldt_pkg::stamp_type age;
   logic               expired;

   // time going backwards counts as age zero
   assign age     = (ctrl.now >= entry_ff.stamp) ? (ctrl.now - entry_ff.stamp) : '0;
   assign expired = (age >= ctrl.threshold);

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      drop_in  = drop_ff;
      unique case (ctrl.op)
         ldt_pkg::OP_HOLD: begin
         end
         ldt_pkg::OP_MARK: begin
            drop_in = entry_ff.valid && expired;
            if (entry_ff.valid && expired) begin
               entry_in.valid = 1'b0;
            end
         end
         ldt_pkg::OP_COMPACT: begin
            // odd-even exchange: a hole swaps with the valid entry on its right
            if (pair_right) begin
               if (!entry_ff.valid && right_in.entry.valid) begin
                  entry_in = right_in.entry;
               end
            end else begin
               if (!left_in.entry.valid && entry_ff.valid) begin
                  entry_in = left_in.entry;
               end
            end
         end
         ldt_pkg::OP_SEARCH: begin
            hit_in = entry_ff.valid && (entry_ff.key == ctrl.key);
         end
         ldt_pkg::OP_MOVE: begin
            // the hit entry steps one place toward the front
            if (hit_ff) begin
               entry_in = left_in.entry;
               hit_in   = 1'b0;
            end else if (right_in.hit) begin
               entry_in = right_in.entry;
               hit_in   = 1'b1;
            end
         end
         ldt_pkg::OP_REFRESH: begin
            if (hit_ff) begin
               entry_in.stamp = ctrl.now;
            end
            hit_in = 1'b0;
         end
         ldt_pkg::OP_INSERT: begin
            entry_in = left_in.entry;
            hit_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // key and stamp carry no reset; only the flags are cleared
   always_ff @(posedge clock) begin
      entry_ff.key   <= entry_in.key;
      entry_ff.stamp <= entry_in.stamp;
      if (reset) begin
         entry_ff.valid <= 1'b0;
         hit_ff         <= 1'b0;
         drop_ff        <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         hit_ff         <= hit_in;
         drop_ff        <= drop_in;
      end
   end

   assign status.entry = entry_ff;
   assign status.hit   = hit_ff;
   assign status.drop  = drop_ff;

endmodule

FILE: src/lru_dedup_table_with_expiry.sv
// A command marks expired entries, then runs the N-round odd-even compaction
// (N = MAX_ENTRIES); a record then searches for its key and inserts it on a
// miss, or moves the hit entry one step a cycle to the front. busy stays high
// until the result strobe, so a new command is taken only after the last ends.
// rsp_valid is a one-cycle strobe.
// Synchronous active-high reset empties the table and sets threshold to 3600.
module lru_dedup_table_with_expiry #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   // command channel
   input  logic             start,
   output logic             busy,
   input  ldt_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   output ldt_pkg::rsp_type rsp_data,
   // threshold register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MARK    = 3'd1;
   localparam logic [2:0] S_COMPACT = 3'd2;
   localparam logic [2:0] S_SEARCH  = 3'd3;
   localparam logic [2:0] S_MOVE    = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                busy_ff, busy_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       dropped_ff, dropped_in;
   logic [CW-1:0]       live_ff, live_in;
   logic                command_ff, command_in;
   ldt_pkg::key_type    key_ff, key_in;
   ldt_pkg::stamp_type  now_ff, now_in;
   ldt_pkg::stamp_type  threshold_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   ldt_pkg::rsp_type    rsp_ff, rsp_in;

   ldt_pkg::op_type         op;
   logic                    phase;
   ldt_pkg::cell_ctrl_type  ctrl;
   ldt_pkg::cell_status_type status [MAX_ENTRIES];
   ldt_pkg::cell_status_type left_edge, right_edge;
   logic [MAX_ENTRIES-1:0]  hit_vec, valid_vec, drop_vec, pair_right;
   logic                    hit_any;
   logic [CW-1:0]           drop_sum;
   logic                    full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 32'd3600;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------
   // Cell chain. Index 0 is the most recent entry; valid entries are
   // kept packed at the low end. The left edge carries the entry to be
   // inserted (and reads as valid, which keeps cell 0 out of compaction
   // swaps); the right edge is an empty slot.
   // ---------------------------------------------------------------
   assign left_edge.entry.valid  = 1'b1;
   assign left_edge.entry.key    = key_ff;
   assign left_edge.entry.stamp  = now_ff;
   assign left_edge.hit          = 1'b0;
   assign left_edge.drop         = 1'b0;
   assign right_edge             = '0;

   assign ctrl.op        = op;
   assign ctrl.key       = key_ff;
   assign ctrl.now       = now_ff;
   assign ctrl.threshold = threshold_ff;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam logic PAR = 1'(i % 2);
      ldt_pkg::cell_status_type left_nb, right_nb;

      if (i == 0) begin : g_first
         assign left_nb = left_edge;
      end else begin : g_mid_l
         assign left_nb = status[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign right_nb = right_edge;
      end else begin : g_mid_r
         assign right_nb = status[i+1];
      end

      // pairs (i, i+1) with i of the current parity exchange this round
      assign pair_right[i] = (PAR == phase);

      ldt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .pair_right (pair_right[i]),
         .left_in    (left_nb),
         .right_in   (right_nb),
         .status     (status[i])
      );

      assign hit_vec[i]   = status[i].hit;
      assign valid_vec[i] = status[i].entry.valid;
      assign drop_vec[i]  = status[i].drop;
   end

   assign hit_any  = |hit_vec;
   assign phase    = cnt_ff[0];
   // drop flags stay in place while entries move, so a scan counts them
   assign drop_sum = dropped_ff + CW'(drop_vec[cnt_ff]);
   assign full     = (live_ff == CW'(MAX_ENTRIES));

   // ---------------------------------------------------------------
   // Sequencer: mark expired, compact N rounds (counting drops), then
   // for a record command search, walk the hit to the front or insert.
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      dropped_in   = dropped_ff;
      live_in      = live_ff;
      command_in   = command_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      op           = ldt_pkg::OP_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               command_in = req_data.command;
               key_in     = ldt_pkg::make_key(req_data);
               now_in     = req_data.now;
               busy_in    = 1'b1;
               state_in   = S_MARK;
            end
         end
         S_MARK: begin
            op         = ldt_pkg::OP_MARK;
            cnt_in     = '0;
            dropped_in = '0;
            state_in   = S_COMPACT;
         end
         S_COMPACT: begin
            op         = ldt_pkg::OP_COMPACT;
            dropped_in = drop_sum;
            if (cnt_ff == IW'(MAX_ENTRIES - 1)) begin
               live_in = live_ff - drop_sum;
               if (command_ff == ldt_pkg::CMD_PRUNE) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.outcome      = ldt_pkg::OUT_PRUNE;
                  rsp_in.live_count   = ldt_pkg::count_type'(live_ff - drop_sum);
                  rsp_in.pruned_count = ldt_pkg::count_type'(drop_sum);
                  busy_in             = 1'b0;
                  state_in            = S_IDLE;
               end else begin
                  state_in = S_SEARCH;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SEARCH: begin
            op       = ldt_pkg::OP_SEARCH;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            if (!hit_any) begin
               // miss: shift everything back one place, tail falls off if full
               op                  = ldt_pkg::OP_INSERT;
               live_in             = full ? live_ff : live_ff + 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.outcome      = full ? ldt_pkg::OUT_EVICT : ldt_pkg::OUT_INSERT;
               rsp_in.live_count   = ldt_pkg::count_type'(full ? live_ff : live_ff + 1'b1);
               rsp_in.pruned_count = ldt_pkg::count_type'(dropped_ff);
               busy_in             = 1'b0;
               state_in            = S_IDLE;
            end else if (hit_vec[0]) begin
               op                  = ldt_pkg::OP_REFRESH;
               rsp_valid_in        = 1'b1;
               rsp_in.outcome      = ldt_pkg::OUT_REFRESH;
               rsp_in.live_count   = ldt_pkg::count_type'(live_ff);
               rsp_in.pruned_count = ldt_pkg::count_type'(dropped_ff);
               busy_in             = 1'b0;
               state_in            = S_IDLE;
            end else begin
               op = ldt_pkg::OP_MOVE;
            end
         end
         default: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      dropped_ff <= dropped_in;
      command_ff <= command_in;
      key_ff     <= key_in;
      now_ff     <= now_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // result strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   // an accepted command keeps the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted start");

   // between commands the valid entries are packed at the front
   a_packed_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (((valid_vec + 1'b1) & valid_vec) == '0))
      else $error("valid entries not packed at the front");

   // live count tracks the number of valid cells between commands
   a_live_matches: assert property (@(posedge clock) disable iff (reset)
      !busy |-> ($countones(valid_vec) == int'(live_ff)))
      else $error("live count disagrees with valid cells");

   // at most one key matches
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell flagged as hit");
`endif

endmodule
